@@ src/trvs_pkg.sv @@
// ----------------------------------------------------------------------------
// trvs_pkg: shared types for the victim select block
// Request codes, controller states and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package trvs_pkg;

    localparam int REQ_TYPE_W  = 2;
    localparam int SET_INDEX_W = 6;
    localparam int WAY_W       = 3;
    localparam int NOW_W       = 32;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_INVALIDATE = 2'd0,
        REQ_TOUCH      = 2'd1,
        REQ_FILL       = 2'd2,
        REQ_VICTIM     = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SCAN,
        ST_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic clr_we;
        logic req_we;
        logic rd_req;
        logic scan_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        req_kind_t in_kind;
        logic      in_set_ok;
        logic      in_way_ok;
        logic      scan_last;
        logic      clr_last;
        logic      out_free;
    } status_t;

endpackage

@@ src/trvs_req_if.sv @@
// ----------------------------------------------------------------------------
// trvs_req_if: request channel
// Carries one request word: kind, set, way and time stamp.
// ----------------------------------------------------------------------------
interface trvs_req_if
    import trvs_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [REQ_TYPE_W-1:0]  req_type;
    logic [SET_INDEX_W-1:0] set_index;
    logic [WAY_W-1:0]       way;
    logic [NOW_W-1:0]       now;

    modport source (output valid, output req_type, output set_index, output way,
                    output now, input ready);
    modport sink   (input valid, input req_type, input set_index, input way,
                    input now, output ready);
endinterface

@@ src/trvs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// trvs_rsp_if: response channel
// Carries one response word for each request.
// ----------------------------------------------------------------------------
interface trvs_rsp_if
    import trvs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             victim_valid;
    logic [WAY_W-1:0] victim_way;

    modport source (output valid, output victim_valid, output victim_way, input ready);
    modport sink   (input valid, input victim_valid, input victim_way, output ready);
endinterface

@@ src/trvs_ctrl.sv @@
// ----------------------------------------------------------------------------
// trvs_ctrl: sequencer for the victim select block
// Runs the clearing pass, dispatches each request and issues the memory,
// scan and response commands to the datapath.
// ----------------------------------------------------------------------------
module trvs_ctrl
    import trvs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.in_kind == REQ_VICTIM)
                    begin
                        state_next = status.in_set_ok ? ST_SCAN : ST_RESP;
                    end
                    else if (!(status.in_set_ok && status.in_way_ok))
                    begin
                        state_next = ST_RESP;
                    end
                    else if (status.in_kind == REQ_TOUCH)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_req = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.req_we = 1'b1;
                state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ src/trvs_datapath.sv @@
// ----------------------------------------------------------------------------
// trvs_datapath: replacement state store and victim scan
// Holds the stamp and count of every way, performs the read-modify-write of
// touch and the one-way-per-cycle victim scan, and registers the response.
// ----------------------------------------------------------------------------
module trvs_datapath
    import trvs_pkg::*;
#(
    parameter int WAYS       = 8,
    parameter int SETS       = 64,
    parameter int STAMP_BITS = 32,
    parameter int COUNT_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [REQ_TYPE_W-1:0]  in_req_type,
    input  logic [SET_INDEX_W-1:0] in_set_index,
    input  logic [WAY_W-1:0]       in_way,
    input  logic [NOW_W-1:0]       in_now,
    input  cmd_t                   cmd,
    output status_t                status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_victim_valid,
    output logic [WAY_W-1:0]       out_victim_way
);

    localparam int DEPTH = SETS * WAYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(WAYS);
    localparam int CW    = $clog2(WAYS + 1);
    localparam int EW    = STAMP_BITS + COUNT_BITS;

    logic [EW-1:0] mem [DEPTH];

    req_kind_t             kind_reg;
    logic                  set_ok_reg;
    logic [AW-1:0]         base_reg;
    logic [AW-1:0]         addr_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic [CW-1:0]         scan_cnt_reg;
    logic [EW-1:0]         rdata_reg;

    logic [WW-1:0]         c1_way_reg;
    logic [STAMP_BITS-1:0] c1_stamp_reg;
    logic [COUNT_BITS-1:0] c1_count_reg;
    logic                  moved_reg;
    logic [WW-1:0]         c2_way_reg;
    logic [STAMP_BITS-1:0] c2_stamp_reg;

    logic                  out_valid_reg;
    logic                  victim_valid_reg;
    logic [WAY_W-1:0]      victim_way_reg;

    logic [63:0]           now_ext;
    logic [AW-1:0]         in_base;
    logic                  scan_rd;
    logic                  scan_cmp;
    logic [WW-1:0]         cmp_way;
    logic                  rd_en;
    logic [AW-1:0]         raddr;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [EW-1:0]         wdata;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic [COUNT_BITS-1:0] rd_count;
    logic [COUNT_BITS-1:0] count_sat;
    logic [WW-1:0]         best_way;
    logic [31:0]           best_ext;

    assign now_ext = {32'd0, in_now};
    assign in_base = AW'(32'(in_set_index) * 32'(WAYS));

    assign status.in_kind   = req_kind_t'(in_req_type);
    assign status.in_set_ok = 32'(in_set_index) < 32'(SETS);
    assign status.in_way_ok = 32'(in_way) < 32'(WAYS);
    assign status.scan_last = scan_cnt_reg == CW'(WAYS);
    assign status.clr_last  = clr_cnt_reg == AW'(DEPTH - 1);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign scan_rd  = cmd.scan_step && (scan_cnt_reg < CW'(WAYS));
    assign scan_cmp = cmd.scan_step && (scan_cnt_reg != '0);
    assign cmp_way  = WW'(scan_cnt_reg - CW'(1));
    assign rd_en    = scan_rd || cmd.rd_req;
    assign raddr    = cmd.scan_step ? (base_reg + AW'(scan_cnt_reg)) : addr_reg;

    assign rd_stamp  = rdata_reg[EW-1:COUNT_BITS];
    assign rd_count  = rdata_reg[COUNT_BITS-1:0];
    assign count_sat = (rd_count == '1) ? rd_count : (rd_count + COUNT_BITS'(1));

    assign we    = cmd.clr_we || cmd.req_we;
    assign waddr = cmd.clr_we ? clr_cnt_reg : addr_reg;

    always_comb
    begin
        wdata = '0;
        if (!cmd.clr_we)
        begin
            case (kind_reg)
                REQ_TOUCH:      wdata = {stamp_reg, count_sat};
                REQ_FILL:       wdata = {stamp_reg, COUNT_BITS'(1)};
                REQ_INVALIDATE: wdata = '0;
                default:        wdata = '0;
            endcase
        end
    end

    assign best_way = moved_reg ? c1_way_reg : c2_way_reg;
    assign best_ext = 32'(best_way);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= req_kind_t'(in_req_type);
            set_ok_reg <= status.in_set_ok;
            base_reg   <= in_base;
            addr_reg   <= in_base + AW'(in_way);
            stamp_reg  <= now_ext[STAMP_BITS-1:0];
        end
        if (scan_cmp)
        begin
            if (scan_cnt_reg == CW'(1))
            begin
                c1_way_reg   <= '0;
                c1_stamp_reg <= rd_stamp;
                c1_count_reg <= rd_count;
                moved_reg    <= 1'b0;
                c2_way_reg   <= '0;
                c2_stamp_reg <= rd_stamp;
            end
            else
            begin
                if ((rd_stamp < c1_stamp_reg) && (rd_count < c1_count_reg))
                begin
                    c1_way_reg   <= cmp_way;
                    c1_stamp_reg <= rd_stamp;
                    c1_count_reg <= rd_count;
                    moved_reg    <= 1'b1;
                end
                if (rd_stamp < c2_stamp_reg)
                begin
                    c2_way_reg   <= cmp_way;
                    c2_stamp_reg <= rd_stamp;
                end
            end
        end
        if (cmd.load_out)
        begin
            victim_valid_reg <= kind_reg == REQ_VICTIM;
            victim_way_reg   <= ((kind_reg == REQ_VICTIM) && set_ok_reg) ?
                                best_ext[WAY_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_we)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.capture)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_cnt_reg <= scan_cnt_reg + CW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_victim_valid = victim_valid_reg;
    assign out_victim_way   = victim_way_reg;

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("Response loaded while the output word is still pending.");

    a_load_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("Loaded response word is not presented.");

    a_touch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.req_we && (kind_reg == REQ_TOUCH)) |-> $past(cmd.rd_req))
        else $error("Touch write without the read of the old count.");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !we)
        else $error("Store written during a victim scan.");
`endif

endmodule

@@ src/timestamp_refcount_victim_select.sv @@
// ----------------------------------------------------------------------------
// timestamp_refcount_victim_select: cache replacement state and victim choice
// Keeps a stamp and a reference count for every way of every set and picks
// the way to replace in a set on request.
//
//   channel  modport  word
//   req      sink     req_type, set_index, way, now
//   rsp      source   victim_valid, victim_way
//
// Invalidate and fill pass through ST_WRITE to ST_RESP, touch through ST_READ
// and ST_WRITE, a victim through ST_SCAN, the one-way-per-cycle scan over the
// single read port of the store. Out-of-range requests go straight to ST_RESP.
// After reset a clearing pass writes zero to all SETS * WAYS entries, one per
// cycle, before the first request is accepted.
// A stalled response holds in the output register; the next request is taken
// meanwhile and waits only when its own response is ready.
// ----------------------------------------------------------------------------
module timestamp_refcount_victim_select
    import trvs_pkg::*;
#(
    parameter int WAYS       = 8,
    parameter int SETS       = 64,
    parameter int STAMP_BITS = 32,
    parameter int COUNT_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    trvs_req_if.sink   req,
    trvs_rsp_if.source rsp
);

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    trvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    trvs_datapath #(
        .WAYS       (WAYS),
        .SETS       (SETS),
        .STAMP_BITS (STAMP_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_req_type      (req.req_type),
        .in_set_index     (req.set_index),
        .in_way           (req.way),
        .in_now           (req.now),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_victim_valid (rsp.victim_valid),
        .out_victim_way   (rsp.victim_way)
    );

    assign req.ready = in_ready;

endmodule
